// ===== src/prt_pkg.sv =====
// prt_pkg: shared types, codes and constants for the prefix route table
// used by prt_cell and prefix_route_table_core
package prt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  // width used to compare a cell position with the 4-bit delete position
  localparam int POS_CMP_W = 9;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DEL    = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_DIRECT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [31:0] NO_ROUTE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] network;
    logic [31:0] gateway;
    logic        is_static;
  } route_t;

  // item held for the whole time the cell row works on it
  typedef struct packed {
    logic [1:0]  action;
    route_t      route;
    logic [3:0]  del_pos;
    logic [31:0] addr;
  } cmd_t;

  // phase strobes from the controller to every cell
  typedef struct packed {
    logic eval;
    logic ins;
    logic del;
  } phase_t;

endpackage

// ===== src/prt_cell.sv =====
// prt_cell: one route table entry with its local compare logic
// neighbors shift entries in and out of it; depends on prt_pkg
module prt_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  prt_pkg::cmd_t   cmd,
  input  prt_pkg::phase_t ph,
  input  logic            live,
  input  logic            prev_pass,
  input  prt_pkg::route_t prev_entry,
  input  prt_pkg::route_t next_entry,
  output prt_pkg::route_t entry,
  output logic            pass,
  output logic            match,
  output logic            sel_static
);

  localparam int POS_CMP_W = prt_pkg::POS_CMP_W;

  prt_pkg::route_t entry_r;
  logic            match_r;
  logic            pass_r;
  logic            after_r;
  logic            sel_r;
  logic            match_nxt;
  logic            pass_nxt;

  always_comb begin
    match_nxt = live && ((cmd.addr & entry_r.mask) == entry_r.network);
    if (cmd.route.is_static) begin
      pass_nxt = live && (!entry_r.is_static || (entry_r.mask > cmd.route.mask));
    end else begin
      pass_nxt = live && !entry_r.is_static;
    end
  end

  always_ff @(posedge clk) begin
    if (ph.eval) begin
      match_r <= match_nxt;
      pass_r  <= pass_nxt;
      after_r <= POS_CMP_W'(IDX) >= POS_CMP_W'(cmd.del_pos);
      sel_r   <= POS_CMP_W'(IDX) == POS_CMP_W'(cmd.del_pos);
    end
    if (ph.ins) begin
      if (!prev_pass) begin
        entry_r <= prev_entry;
      end else if (!pass_r) begin
        entry_r <= cmd.route;
      end
    end else if (ph.del && after_r) begin
      entry_r <= next_entry;
    end
  end

  assign entry      = entry_r;
  assign pass       = pass_r;
  assign match      = match_r;
  assign sel_static = sel_r & entry_r.is_static;

endmodule

// ===== src/prt_pick.sv =====
// prt_pick: first-hit select over the row of cell match flags
// returns the gateway of the lowest matching cell; no package use
module prt_pick #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0] hits,
  input  logic [31:0]      gws [DEPTH],
  output logic             any_hit,
  output logic [31:0]      gw
);

  logic [DEPTH-1:0] first;

  always_comb begin
    // isolate the lowest set bit
    first   = hits & (~hits + DEPTH'(1));
    any_hit = |hits;
    gw      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gw = gw | (gws[i] & {32{first[i]}});
    end
  end

endmodule

// ===== src/prefix_route_table_core.sv =====
// prefix_route_table_core: ordered ipv4 route table built as a row of cells
// depends on prt_pkg, prt_cell and prt_pick
//
// usage
//   input channel in_*: one item per handshake (in_valid high, in_stall low),
//   action add, delete by position or look up an address
//   result channel out_*: exactly one result item per input item, held in an
//   output register until taken (out_valid high, out_stall low)
// timing
//   an item passes through an eval cycle, where every cell
//   compares its own entry and registers its match and insert flags, then an
//   apply cycle where the first hit is picked, entries shift one cell up or
//   down and the result is registered, which sets out_valid
//   a new item is not taken during eval; the next item is taken in the apply
//   cycle of the previous one, once its result can be committed
// reset
//   synchronous active-low rst_n empties the table (entry count zero) and
//   drops any pending result; entry contents are not cleared
// back-pressure
//   while out_stall holds a finished result, the block stays in apply with
//   the table unchanged and in_stall stays high
module prefix_route_table_core #(
  parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_new_mask,
  input  logic [31:0] in_new_network,
  input  logic [31:0] in_new_gateway,
  input  logic        in_new_is_static,
  input  logic [3:0]  in_delete_position,
  input  logic [31:0] in_lookup_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [31:0] out_hop_addr,
  output logic [4:0]  out_entry_count
);

  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int POS_CMP_W = prt_pkg::POS_CMP_W;

  // control states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  prt_pkg::cmd_t     cmd_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r;
  logic [1:0]        status_r, status_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       hop_r, hop_nxt;
  logic [4:0]        ecount_r;

  logic              accept;
  logic              out_free;
  logic              done;
  logic              full;
  logic              del_range_ok;
  logic              del_static;
  prt_pkg::phase_t   ph;

  // cell row wiring
  prt_pkg::route_t   entries [TABLE_DEPTH];
  logic [31:0]       gws     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] pass_v;
  logic [TABLE_DEPTH-1:0] match_v;
  logic [TABLE_DEPTH-1:0] sel_static_v;
  logic              any_hit;
  logic [31:0]       hit_gw;

  // a finished result can be placed when the output register is free now
  assign out_free = !out_valid_r || !out_stall;
  assign done     = (state_r == S_APPLY) && out_free;
  assign in_stall = !((state_r == S_IDLE) || done);
  assign accept   = in_valid && !in_stall;

  assign full         = count_r == CNT_W'(TABLE_DEPTH);
  assign del_range_ok = POS_CMP_W'(cmd_r.del_pos) < POS_CMP_W'(count_r);
  assign del_static   = |sel_static_v;

  // phase strobes; table changes only when the result is committed
  always_comb begin
    ph.eval = state_r == S_EVAL;
    ph.ins  = done && (cmd_r.action == prt_pkg::ACT_ADD) && !full;
    ph.del  = done && (cmd_r.action == prt_pkg::ACT_DEL) && del_range_ok && del_static;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic            live;
      logic            prev_pass;
      prt_pkg::route_t prev_entry;
      prt_pkg::route_t next_entry;

      assign live = CNT_W'(g) < count_r;

      if (g == 0) begin : g_head
        // head cell: the insert point can only be here or further up
        assign prev_pass  = 1'b1;
        assign prev_entry = cmd_r.route;
      end else begin : g_body
        assign prev_pass  = pass_v[g-1];
        assign prev_entry = entries[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_tail
        // tail cell: its entry falls out of range on delete
        assign next_entry = entries[g];
      end else begin : g_mid
        assign next_entry = entries[g+1];
      end

      prt_cell #(
        .IDX (g)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd_r),
        .ph         (ph),
        .live       (live),
        .prev_pass  (prev_pass),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .entry      (entries[g]),
        .pass       (pass_v[g]),
        .match      (match_v[g]),
        .sel_static (sel_static_v[g])
      );

      assign gws[g] = entries[g].gateway;
    end
  endgenerate

  prt_pick #(
    .DEPTH (TABLE_DEPTH)
  ) u_pick (
    .hits    (match_v),
    .gws     (gws),
    .any_hit (any_hit),
    .gw      (hit_gw)
  );

  // result of the item in apply
  always_comb begin
    status_nxt = prt_pkg::ST_OK;
    found_nxt  = 1'b0;
    hop_nxt    = prt_pkg::NO_ROUTE;
    count_nxt  = count_r;
    case (cmd_r.action)
      prt_pkg::ACT_ADD: begin
        hop_nxt = '0;
        if (full) begin
          status_nxt = prt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      prt_pkg::ACT_DEL: begin
        hop_nxt = '0;
        if (!del_range_ok) begin
          status_nxt = prt_pkg::ST_RANGE;
        end else if (!del_static) begin
          status_nxt = prt_pkg::ST_DIRECT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      prt_pkg::ACT_LOOKUP: begin
        if (any_hit) begin
          found_nxt = 1'b1;
          // zero gateway means directly connected
          hop_nxt   = (hit_gw == '0) ? cmd_r.addr : hit_gw;
        end
      end
      default: begin
        // unused action code: no change, no-route result
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (done) begin
          state_nxt = accept ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.action          <= in_action;
      cmd_r.route.mask      <= in_new_mask;
      cmd_r.route.network   <= in_new_network;
      cmd_r.route.gateway   <= in_new_gateway;
      cmd_r.route.is_static <= in_new_is_static;
      cmd_r.del_pos         <= in_delete_position;
      cmd_r.addr            <= in_lookup_address;
    end
    if (done) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      hop_r    <= hop_nxt;
      ecount_r <= 5'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_hop_addr    = hop_r;
  assign out_entry_count = ecount_r;

endmodule
